// File: rtl/sm83_pkg.sv
// package: operation codes, flag positions and the alu function for the sm83 alu
package sm83_pkg;

  typedef enum logic [4:0] {
    ACT_ADD  = 5'd0,
    ACT_ADC  = 5'd1,
    ACT_SUB  = 5'd2,
    ACT_SBC  = 5'd3,
    ACT_AND  = 5'd4,
    ACT_XOR  = 5'd5,
    ACT_OR   = 5'd6,
    ACT_CP   = 5'd7,
    ACT_INC  = 5'd8,
    ACT_DEC  = 5'd9,
    ACT_DAA  = 5'd10,
    ACT_CPL  = 5'd11,
    ACT_SCF  = 5'd12,
    ACT_CCF  = 5'd13,
    ACT_RLCA = 5'd14,
    ACT_RRCA = 5'd15,
    ACT_RLA  = 5'd16,
    ACT_RRA  = 5'd17,
    ACT_RLC  = 5'd18,
    ACT_RRC  = 5'd19,
    ACT_RL   = 5'd20,
    ACT_RR   = 5'd21,
    ACT_SLA  = 5'd22,
    ACT_SRA  = 5'd23,
    ACT_SWAP = 5'd24,
    ACT_SRL  = 5'd25,
    ACT_BIT  = 5'd26,
    ACT_RES  = 5'd27,
    ACT_SET  = 5'd28
  } action_t;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;

  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags;
    logic       written;
  } alu_res_t;

  function automatic alu_res_t alu_exec(input logic [4:0] action, input logic [7:0] a,
                                        input logic [7:0] b, input logic [3:0] f,
                                        input logic [2:0] idx);
    alu_res_t   res;
    logic       cin;
    logic       t;
    logic [8:0] wide;
    logic [4:0] half;
    logic [7:0] r;
    logic [7:0] adj;
    logic       lo_fix;
    logic       hi_fix;
    cin     = f[FLAG_C];
    t       = 1'b0;
    wide    = 9'd0;
    half    = 5'd0;
    r       = a;
    adj     = 8'd0;
    lo_fix  = 1'b0;
    hi_fix  = 1'b0;
    res.result  = a;
    res.flags   = f;
    res.written = 1'b1;
    unique case (action_t'(action))
      ACT_ADD, ACT_ADC: begin
        t    = (action_t'(action) == ACT_ADC) ? cin : 1'b0;
        wide = {1'b0, a} + {1'b0, b} + {8'd0, t};
        half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
        res.result = wide[7:0];
        res.flags  = {wide[7:0] == 8'd0, 1'b0, half[4], wide[8]};
      end
      ACT_SUB, ACT_SBC, ACT_CP: begin
        t    = (action_t'(action) == ACT_SBC) ? cin : 1'b0;
        // top bit of the widened difference is the borrow
        wide = {1'b0, a} - {1'b0, b} - {8'd0, t};
        half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
        res.flags = {wide[7:0] == 8'd0, 1'b1, half[4], wide[8]};
        if (action_t'(action) == ACT_CP) begin
          res.written = 1'b0;
        end else begin
          res.result = wide[7:0];
        end
      end
      ACT_AND: begin
        r = a & b;
        res.result = r;
        res.flags  = {r == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      ACT_XOR: begin
        r = a ^ b;
        res.result = r;
        res.flags  = {r == 8'd0, 3'b000};
      end
      ACT_OR: begin
        r = a | b;
        res.result = r;
        res.flags  = {r == 8'd0, 3'b000};
      end
      ACT_INC: begin
        r = a + 8'd1;
        res.result = r;
        res.flags  = {r == 8'd0, 1'b0, r[3:0] == 4'h0, cin};
      end
      ACT_DEC: begin
        r = a - 8'd1;
        res.result = r;
        res.flags  = {r == 8'd0, 1'b1, r[3:0] == 4'hF, cin};
      end
      ACT_DAA: begin
        lo_fix = f[FLAG_H] || (!f[FLAG_N] && (a[3:0] > DAA_LO_LIMIT));
        hi_fix = cin || (!f[FLAG_N] && (a > DAA_HI_LIMIT));
        adj    = (lo_fix ? DAA_LO_ADJ : 8'd0) | (hi_fix ? DAA_HI_ADJ : 8'd0);
        r      = f[FLAG_N] ? (a - adj) : (a + adj);
        res.result = r;
        res.flags  = {r == 8'd0, f[FLAG_N], 1'b0, hi_fix};
      end
      ACT_CPL: begin
        res.result = ~a;
        res.flags  = {f[FLAG_Z], 1'b1, 1'b1, cin};
      end
      ACT_SCF: begin
        res.written = 1'b0;
        res.flags   = {f[FLAG_Z], 2'b00, 1'b1};
      end
      ACT_CCF: begin
        res.written = 1'b0;
        res.flags   = {f[FLAG_Z], 2'b00, ~cin};
      end
      ACT_RLCA: begin
        res.result = {a[6:0], a[7]};
        res.flags  = {3'b000, a[7]};
      end
      ACT_RRCA: begin
        res.result = {a[0], a[7:1]};
        res.flags  = {3'b000, a[0]};
      end
      ACT_RLA: begin
        res.result = {a[6:0], cin};
        res.flags  = {3'b000, a[7]};
      end
      ACT_RRA: begin
        res.result = {cin, a[7:1]};
        res.flags  = {3'b000, a[0]};
      end
      ACT_RLC, ACT_RRC, ACT_RL, ACT_RR, ACT_SLA, ACT_SRA, ACT_SWAP, ACT_SRL: begin
        unique case (action_t'(action))
          ACT_RLC: begin
            r = {a[6:0], a[7]};
            t = a[7];
          end
          ACT_RRC: begin
            r = {a[0], a[7:1]};
            t = a[0];
          end
          ACT_RL: begin
            r = {a[6:0], cin};
            t = a[7];
          end
          ACT_RR: begin
            r = {cin, a[7:1]};
            t = a[0];
          end
          ACT_SLA: begin
            r = {a[6:0], 1'b0};
            t = a[7];
          end
          ACT_SRA: begin
            r = {a[7], a[7:1]};
            t = a[0];
          end
          ACT_SWAP: begin
            r = {a[3:0], a[7:4]};
            t = 1'b0;
          end
          default: begin
            r = {1'b0, a[7:1]};
            t = a[0];
          end
        endcase
        res.result = r;
        res.flags  = {r == 8'd0, 2'b00, t};
      end
      ACT_BIT: begin
        res.written = 1'b0;
        res.flags   = {~a[idx], 1'b0, 1'b1, cin};
      end
      ACT_RES: begin
        res.result = a & ~(8'd1 << idx);
      end
      ACT_SET: begin
        res.result = a | (8'd1 << idx);
      end
      default: begin
        // codes past set do nothing
        res.written = 1'b0;
      end
    endcase
    return res;
  endfunction

endpackage

// File: rtl/sm83_alu_with_bit_ops.sv
// top level: registered 8-bit alu with rotate, shift, swap and bit operations
// One request per clock cycle goes in and one result per cycle comes out while out_stall
// is low. A request taken at one edge lands in the input register, the alu function runs
// between that register and the result register, and the result shows on the output once
// the result register takes it, and holds there while out_stall is high. in_stall
// rises only while both registers are full and the output is stalled; it follows
// out_stall in the same cycle. Reset empties both registers; there is no other state.
module sm83_alu_with_bit_ops
  import sm83_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] action,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  input  logic [3:0] flags_in,
  input  logic [2:0] bit_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] result,
  output logic [3:0] flags_out,
  output logic       result_written
);

  logic       req_valid;
  logic [4:0] req_action;
  logic [7:0] req_a;
  logic [7:0] req_b;
  logic [3:0] req_flags;
  logic [2:0] req_index;
  logic       out_adv;
  logic       req_adv;
  alu_res_t   alu_next;

  assign out_adv  = !out_valid || !out_stall;
  assign req_adv  = !req_valid || out_adv;
  assign in_stall = !req_adv;

  assign alu_next = alu_exec(req_action, req_a, req_b, req_flags, req_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req_adv) begin
        req_valid <= in_valid;
      end
      if (out_adv) begin
        out_valid <= req_valid;
      end
    end
    if (req_adv && in_valid) begin
      req_action <= action;
      req_a      <= operand_a;
      req_b      <= operand_b;
      req_flags  <= flags_in;
      req_index  <= bit_index;
    end
    if (out_adv && req_valid) begin
      result         <= alu_next.result;
      flags_out      <= alu_next.flags;
      result_written <= alu_next.written;
    end
  end

endmodule

// File: rtl/sm83_alu_chk.sv
// checker on the ports of the sm83 alu, bound to the top level
module sm83_alu_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [4:0] action,
  input logic [7:0] operand_a,
  input logic [7:0] operand_b,
  input logic [3:0] flags_in,
  input logic [2:0] bit_index,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] result,
  input logic [3:0] flags_out,
  input logic       result_written
);

  // input backs up only when the output side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  a_drain_frees_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |-> !in_stall)
    else $error("in_stall while the result is taken");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result) && $stable(flags_out)
                                  && $stable(result_written)))
    else $error("stalled result changed");

  // a stalled request stays on the bus unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (in_valid && $stable(action) && $stable(operand_a)
                                && $stable(operand_b) && $stable(flags_in)
                                && $stable(bit_index)))
    else $error("stalled request changed");

endmodule

bind sm83_alu_with_bit_ops sm83_alu_chk u_sm83_alu_chk (.*);
